### sv/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define CHECK_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Checks that a condition holds in the cycle after a trigger.
`define CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### sv/ktaf_pkg.sv
// Types, constants and helpers for the tilt angle filter.
package ktaf_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int QuoBits   = DataWidth + FracBits;

  typedef logic signed [DataWidth-1:0] q_t;

  localparam logic signed [DataWidth-1:0] QMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] QMin = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] QOne = q_t'(64'sd1 <<< FracBits);

  localparam logic [1:0] RegTimeStep   = 2'd0;
  localparam logic [1:0] RegMeasNoise  = 2'd1;
  localparam logic [1:0] RegBiasNoise  = 2'd2;
  localparam logic [1:0] RegAngleNoise = 2'd3;

  localparam logic OpPredict = 1'b0;
  localparam logic OpCorrect = 1'b1;

  // Saturating sum or difference of two words.
  function automatic q_t sat_add(q_t a, q_t b, logic sub);
    logic signed [DataWidth:0] s;
    begin
      s = sub ? ({a[DataWidth-1], a} - {b[DataWidth-1], b})
              : ({a[DataWidth-1], a} + {b[DataWidth-1], b});
      if (s[DataWidth] != s[DataWidth-1]) sat_add = s[DataWidth] ? QMin : QMax;
      else sat_add = s[DataWidth-1:0];
    end
  endfunction
endpackage

### sv/kalman_tilt_angle_filter.sv
// Top level of the two-state tilt angle Kalman filter.
// Predict beat: each multiply is issued, then its product consumed; a new beat waits for idle.
// Correct beat: two 48-step serial restoring divides and six passes through the one
// multiplier; both divides are skipped when the denominator is not positive.
// Results wait in an output register; a stalled result holds the sequence in its last step.
// Synchronous active-high reset restores state, covariance to identity and registers to defaults.
module kalman_tilt_angle_filter import ktaf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample [31:0]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // angle_estimate, rate_estimate, bias_estimate
);
  `include "assert_macros.svh"

  localparam logic [3:0] StIdle = 4'd0, StPred = 4'd1, StDiv = 4'd2, StCorr = 4'd3,
                         StOut = 4'd4, StMulW = 4'd5;

  logic [16:0] time_step;
  logic [30:0] measure_noise, bias_noise, angle_noise;
  q_t angle_reg, bias_reg, rate_reg, cov_aa, cov_ab, cov_ba, cov_bb;
  q_t sample, err, den, k0, k1, t0, t1, step01;
  logic [3:0] state;
  logic [3:0] step;
  logic [5:0] dcnt;
  logic       dsel;
  logic       out_load;

  // Shared multiplier: operands registered, product registered.
  q_t ma, mb, mres;
  logic [2*DataWidth-1:0] mprod;
  logic mneg;
  always_comb begin
    logic [DataWidth-1:0] ua, ub;
    logic [2*DataWidth-1:0] sh;
    ua = ma[DataWidth-1] ? DataWidth'(-ma) : ma;
    ub = mb[DataWidth-1] ? DataWidth'(-mb) : mb;
    mprod = ua * ub;
    sh = mprod >> FracBits;
    mneg = ma[DataWidth-1] ^ mb[DataWidth-1];
    if (mneg) mres = (sh > {{DataWidth{1'b0}}, QMin}) ? QMin : q_t'(-sh);
    else mres = (sh > {{DataWidth{1'b0}}, QMax}) ? QMax : q_t'(sh);
  end
  q_t mr;
  always_ff @(posedge clk) mr <= mres;

  // Serial divider registers.
  logic [DataWidth:0] rem;
  logic [QuoBits-1:0] quo, dnum;
  logic dneg;
  logic [DataWidth:0] rtry;
  logic [QuoBits-1:0] qnext;
  always_comb begin
    rtry  = {rem[DataWidth-1:0], dnum[QuoBits-1]};
    qnext = {quo[QuoBits-2:0], 1'b0};
    if (rtry >= {1'b0, den}) begin
      rtry = rtry - {1'b0, den};
      qnext[0] = 1'b1;
    end
  end
  q_t dres;
  always_comb begin
    if (dneg) dres = (quo > QuoBits'({1'b0, QMax}) + 1) ? QMin : q_t'(-quo);
    else dres = (quo > QuoBits'({1'b0, QMax})) ? QMax : q_t'(quo);
  end

  function automatic q_t rv(logic [30:0] r);
    rv = q_t'({1'b0, r});
  endfunction

  assign s_axis_tready = (state == StIdle);
  // The result register takes a new beat when it is empty or being emptied.
  assign out_load = (state == StOut) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= 17'd655; measure_noise <= 31'd19661;
      bias_noise <= 31'd197; angle_noise <= 31'd66;
      angle_reg <= '0; bias_reg <= '0; rate_reg <= '0;
      cov_aa <= QOne; cov_ab <= '0; cov_ba <= '0; cov_bb <= QOne;
      state <= StIdle; m_axis_tvalid <= 1'b0; step <= '0;
    end else begin
      // Register writes.
      if (cfg_we) begin
        unique case (cfg_index)
          RegTimeStep:   time_step <= cfg_data[16:0];
          RegMeasNoise:  measure_noise <= cfg_data;
          RegBiasNoise:  bias_noise <= cfg_data;
          RegAngleNoise: angle_noise <= cfg_data;
        endcase
      end
      // Output register.
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {bias_reg, rate_reg, angle_reg};
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            sample <= s_axis_tdata; step <= '0;
            t0 <= cov_aa; t1 <= cov_ab;
            state <= (s_axis_tuser == OpPredict) ? StPred : StCorr;
          end
        end
        // Predict sequence: each multiply issued, then its product consumed.
        StPred: begin
          step <= step + 4'd1;
          unique case (step)
            4'd0: begin
              rate_reg <= sat_add(sample, bias_reg, 1'b1);
              ma <= sat_add(QMin, cov_bb, 1'b1) == QMax && cov_bb == QMin ? QMax
                    : sat_add('0, cov_bb, 1'b1);
              mb <= q_t'({15'd0, time_step});
            end
            4'd1: ;
            4'd2: begin
              step01 <= mr;
              ma <= rate_reg;
            end
            4'd3: ;
            4'd4: begin
              angle_reg <= sat_add(angle_reg, mr, 1'b0);
              ma <= sat_add(sat_add(rv(angle_noise), cov_ab, 1'b1), cov_ba, 1'b1);
            end
            4'd5: ;
            4'd6: begin
              cov_aa <= sat_add(cov_aa, mr, 1'b0);
              ma <= rv(bias_noise);
            end
            4'd7: ;
            default: begin
              cov_bb <= sat_add(cov_bb, mr, 1'b0);
              cov_ab <= sat_add(cov_ab, step01, 1'b0);
              cov_ba <= sat_add(cov_ba, step01, 1'b0);
              state <= StOut;
            end
          endcase
        end
        // Correct sequence: gains by divide, then six multiplies.
        StCorr: begin
          // A denominator that is not positive skips both divides.
          step <= (step == 4'd1 && (den[DataWidth-1] || den == '0)) ? 4'd3 : step + 4'd1;
          unique case (step)
            4'd0: begin
              err <= sat_add(sample, angle_reg, 1'b1);
              den <= sat_add(rv(measure_noise), cov_aa, 1'b0);
              k0 <= '0; k1 <= '0;
            end
            4'd1: begin
              if (!(den[DataWidth-1] || den == '0)) begin
                dsel <= 1'b0; dneg <= cov_aa[DataWidth-1];
                dnum <= {(cov_aa[DataWidth-1] ? DataWidth'(-cov_aa) : cov_aa),
                         {FracBits{1'b0}}};
                rem <= '0; quo <= '0; dcnt <= '0; state <= StDiv;
              end
            end
            4'd2: begin
              dsel <= 1'b1; dneg <= cov_ba[DataWidth-1];
              dnum <= {(cov_ba[DataWidth-1] ? DataWidth'(-cov_ba) : cov_ba),
                       {FracBits{1'b0}}};
              rem <= '0; quo <= '0; dcnt <= '0; state <= StDiv;
            end
            4'd3: begin ma <= k0; mb <= t0; end
            4'd4: begin ma <= k0; mb <= t1; end
            4'd5: begin cov_aa <= sat_add(cov_aa, mr, 1'b1); ma <= k1; mb <= t0; end
            4'd6: begin cov_ab <= sat_add(cov_ab, mr, 1'b1); ma <= k1; mb <= t1; end
            4'd7: begin cov_ba <= sat_add(cov_ba, mr, 1'b1); ma <= k1; mb <= err; end
            4'd8: begin cov_bb <= sat_add(cov_bb, mr, 1'b1); ma <= k0; mb <= err; end
            4'd9: bias_reg <= sat_add(bias_reg, mr, 1'b0);
            default: begin
              angle_reg <= sat_add(angle_reg, mr, 1'b0);
              state <= StOut;
            end
          endcase
        end
        // One quotient bit per cycle.
        StDiv: begin
          rem <= rtry; quo <= qnext; dnum <= {dnum[QuoBits-2:0], 1'b0};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'(QuoBits - 1)) state <= StMulW;
        end
        StMulW: begin
          if (dsel) k1 <= dres; else k0 <= dres;
          state <= StCorr;
        end
        // Wait here while the previous result is still held.
        StOut: begin
          if (out_load) state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end

  `CHECK_IMPL(a_busy_not_ready, state != StIdle, !s_axis_tready)
  `CHECK_NEXT(a_out_after_seq, state == StOut, m_axis_tvalid)
  `CHECK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the two-state tilt angle Kalman filter.
`timescale 1ns / 100ps

module tb_top;
  import ktaf_pkg::*;

  typedef struct {
    logic        op;
    logic [31:0] sample;
  } imu_beat_t;

  typedef struct {
    logic [31:0] angle;
    logic [31:0] rate;
    logic [31:0] bias;
  } estimate_t;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // sample [31:0]
  logic        s_axis_tuser;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // angle [31:0], rate [63:32], bias [95:64]

  imu_beat_t pending_beats[$];
  estimate_t expected_estimates[$];
  imu_beat_t cur_beat;
  int        mismatch_count;
  int        src_idle_pct;
  int        sink_stall_pct;
  bit        src_pause;
  bit        long_hold_req;
  bit        sink_hold;

  // Filter state mirrored by the predictor.
  longint dt_q, r_q, qgyro_q, qangle_q;
  longint angle_q, bias_q, rate_q;
  longint p00, p01, p10, p11;

  kalman_tilt_angle_filter u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clampq(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint from_magnitude(bit neg, bit [63:0] m);
    if (neg) return (m > 64'h8000_0000) ? VMIN : -longint'(m);
    return (m > 64'h7FFF_FFFF) ? VMAX : longint'(m);
  endfunction

  // Fixed point product, truncated toward zero, then saturated.
  function automatic longint fx_mul(longint a, longint b);
    bit        neg;
    bit [63:0] ua, ub;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return from_magnitude(neg, (ua * ub) >> FracBits);
  endfunction

  // Fixed point quotient by restoring division; den is positive.
  function automatic longint fx_div(longint num, longint den);
    bit        neg;
    bit [63:0] un, ud, lim, r, q;
    int        i;
    neg = num < 0;
    un = neg ? -num : num;
    ud = den;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    r = 0;
    q = 0;
    for (i = DataWidth - 1; i >= -FracBits; i--) begin
      r = (r << 1) | ((i >= 0) ? un[i] : 1'b0);
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
      if (q > lim) return neg ? VMIN : VMAX;
    end
    return from_magnitude(neg, q);
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  task automatic reset_filter_state();
    dt_q = 655; r_q = 19661; qgyro_q = 197; qangle_q = 66;
    angle_q = 0; bias_q = 0; rate_q = 0;
    p00 = 65536; p01 = 0; p10 = 0; p11 = 65536;
  endtask

  // Advance the mirrored filter by one input beat and queue the estimate.
  task automatic predict_estimate(imu_beat_t b);
    longint s, pd00, step01, err, e, k0, k1, t0, t1;
    estimate_t est;
    s = sx32(b.sample);
    if (b.op == OpPredict) begin
      pd00 = clampq(clampq(qangle_q - p01) - p10);
      step01 = fx_mul(clampq(-p11), dt_q);
      rate_q = clampq(s - bias_q);
      angle_q = clampq(angle_q + fx_mul(rate_q, dt_q));
      p00 = clampq(p00 + fx_mul(pd00, dt_q));
      p01 = clampq(p01 + step01);
      p10 = clampq(p10 + step01);
      p11 = clampq(p11 + fx_mul(qgyro_q, dt_q));
    end else begin
      err = clampq(s - angle_q);
      e = clampq(r_q + p00);
      k0 = 0;
      k1 = 0;
      t0 = p00;
      t1 = p01;
      // A gain of zero when the innovation variance is not positive.
      if (e > 0) begin
        k0 = fx_div(p00, e);
        k1 = fx_div(p10, e);
      end
      p00 = clampq(p00 - fx_mul(k0, t0));
      p01 = clampq(p01 - fx_mul(k0, t1));
      p10 = clampq(p10 - fx_mul(k1, t0));
      p11 = clampq(p11 - fx_mul(k1, t1));
      bias_q = clampq(bias_q + fx_mul(k1, err));
      angle_q = clampq(angle_q + fx_mul(k0, err));
    end
    est.angle = angle_q[31:0];
    est.rate = rate_q[31:0];
    est.bias = bias_q[31:0];
    expected_estimates.push_back(est);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Input driver: presents queued beats, with random idle cycles.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_estimate(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_beats.size() > 0 && !src_pause &&
            $urandom_range(99) >= src_idle_pct) begin
          cur_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= cur_beat.sample;
          s_axis_tuser <= cur_beat.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted in cycles in its own process.
  initial begin
    sink_hold = 1'b0;
    wait (long_hold_req);
    sink_hold = 1'b1;
    repeat (1500) @(posedge clk);
    sink_hold = 1'b0;
  end

  // Output monitor: random back-pressure, long holds, and field checks.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'h0);
        end else begin
          estimate_t want;
          want = expected_estimates.pop_front();
          if (m_axis_tdata[31:0] !== want.angle)
            report_mismatch("angle", m_axis_tdata[31:0], want.angle);
          if (m_axis_tdata[63:32] !== want.rate)
            report_mismatch("rate", m_axis_tdata[63:32], want.rate);
          if (m_axis_tdata[95:64] !== want.bias)
            report_mismatch("bias", m_axis_tdata[95:64], want.bias);
        end
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Checks after the clock edge has settled, so the driver's update is seen.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_beats.size() != 0 || s_axis_tvalid || expected_estimates.size() != 0);
  endtask

  // Register write while the block is idle; the mirror follows when the write is driven.
  task automatic write_reg(logic [1:0] idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      RegTimeStep:   dt_q = value & 31'h1FFFF;
      RegMeasNoise:  r_q = value;
      RegBiasNoise:  qgyro_q = value;
      default:       qangle_q = value;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_filter(logic [30:0] dt, logic [30:0] r, logic [30:0] qg,
                            logic [30:0] qa);
    wait_drained();
    repeat (150) @(posedge clk);
    write_reg(RegTimeStep, dt);
    write_reg(RegMeasNoise, r);
    write_reg(RegBiasNoise, qg);
    write_reg(RegAngleNoise, qa);
  endtask

  task automatic push_beat(logic op, logic [31:0] sample);
    imu_beat_t b;
    b.op = op;
    b.sample = sample;
    pending_beats.push_back(b);
  endtask

  function automatic logic [31:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    if (pick < 90) return $urandom;
    if (pick < 95) return QMax;
    return QMin;
  endfunction

  // Mostly predict/correct pairs of sensor-like data, with bursts of noise.
  task automatic push_random(int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(9) < 7) push_beat((n % 2) ? OpCorrect : OpPredict, rand_sample());
      else push_beat(1'($urandom), rand_sample());
    end
  endtask

  // Stimulus phases.
  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    mismatch_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    src_pause = 1'b0;
    long_hold_req = 1'b0;
    reset_filter_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at the sample extremes under the reset settings.
    push_beat(OpPredict, 32'h0);
    push_beat(OpPredict, QMax);
    push_beat(OpCorrect, QMax);
    push_beat(OpPredict, QMin);
    push_beat(OpCorrect, QMin);
    push_beat(OpPredict, 32'hFFFF_FFFF);
    push_beat(OpCorrect, 32'h0);
    push_beat(OpPredict, QOne);
    push_beat(OpCorrect, QOne);
    push_beat(OpCorrect, 32'h5A5A_A5A5);
    wait_drained();

    // Zero time step: only the rate follows; zero measurement noise too.
    set_filter(31'd0, 31'd0, 31'd0, 31'd0);
    push_beat(OpPredict, 32'h0003_0000);
    push_beat(OpCorrect, 32'hFFFE_0000);
    push_beat(OpPredict, QMin);
    push_beat(OpCorrect, QMax);
    // Largest noise settings and a unit time step drive the covariance into saturation.
    set_filter(31'h10000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    push_beat(OpPredict, QMax);
    push_beat(OpPredict, QMin);
    push_beat(OpCorrect, QMax);
    push_beat(OpCorrect, QMin);
    push_beat(OpPredict, 32'h1234_5678);
    // Smallest non-zero step.
    set_filter(31'd1, 31'd1, 31'd1, 31'd1);
    push_beat(OpPredict, QMax);
    push_beat(OpCorrect, QMin);

    // Random phases, cycling through the idling modes.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      case (phase)
        0: set_filter(31'd655, 31'd19661, 31'd197, 31'd66);
        4: set_filter(31'h10000, 31'd0, 31'h7FFF_FFFF, 31'd0);
        7: set_filter(31'd0, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
        default: set_filter(31'($urandom_range(0, 31'h1FFFF)),
                            ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(0, 1 << 17)),
                            31'($urandom_range(0, 4096)),
                            ($urandom_range(1)) ? 31'($urandom) : 31'($urandom_range(0, 4096)));
      endcase
      push_random(110);
      if (phase == 1) begin
        // Long receiver hold while the sender keeps offering beats.
        src_idle_pct = 0;
        long_hold_req = 1'b1;
      end
      repeat (2000) @(posedge clk);
      if (phase == 2) begin
        // Sender pauses until every expected estimate has come back.
        src_pause = 1'b1;
        while (expected_estimates.size() != 0 || s_axis_tvalid) @(posedge clk);
        src_pause = 1'b0;
      end
      push_random(110);
      wait_drained();
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (expected_estimates.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
